/* src/bfha_pkg.sv */
// Shared constants, field layout and control types for the best-fit hole allocator.
package bfha_pkg;

  // Default storage shape
  localparam int MAX_HOLES_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed field widths
  localparam int CMD_W    = 1;
  localparam int INDEX_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int LEFT_W   = 16;
  localparam int TOTAL_W  = 32;
  localparam int HIU_W    = 5;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_DATA_W  = 24;
  localparam int IN_PAD_W   = IN_DATA_W - INDEX_W - AMOUNT_W;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - 1 - INDEX_W - LEFT_W - TOTAL_W;

  // Register reset value
  localparam logic [HIU_W-1:0] HIU_RESET = 5'd8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_en;
    logic finish;
  } bfha_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } bfha_sts_t;

endpackage

/* src/bfha_ctrl.sv */
// Sequencer: accept, scan on allocations, then finish into the output register.
module bfha_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfha_pkg::CMD_W-1:0]    s_tuser,
  input  bfha_pkg::bfha_sts_t           sts,
  output bfha_pkg::bfha_ctl_t           ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  // Control output decode
  always_comb begin
    ctl.load    = s_tvalid && (state == S_IDLE);
    ctl.scan_en = (state == S_SCAN);
    ctl.finish  = (state == S_FINISH) && !sts.out_busy;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == bfha_pkg::CMD_ALLOC) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/bfha_datapath.sv */
// Hole table, best-fit scan registers, comparison counter and output register.
module bfha_datapath #(
  parameter int MAX_HOLES = bfha_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = bfha_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bfha_pkg::bfha_ctl_t               ctl,
  output bfha_pkg::bfha_sts_t               sts,
  input  logic [bfha_pkg::CMD_W-1:0]        s_tuser,
  input  logic [bfha_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              cfg_we,
  input  logic [bfha_pkg::HIU_W-1:0]        cfg_wdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bfha_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int AW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);

  // Hole table and per-entry valid bits (invalid reads as empty)
  logic [SIZE_BITS-1:0] mem [MAX_HOLES];
  logic [MAX_HOLES-1:0] valid;

  // Configuration
  logic [bfha_pkg::HIU_W-1:0] holes_in_use;

  // Latched transaction
  logic [bfha_pkg::CMD_W-1:0]   cmd_code;
  logic [bfha_pkg::INDEX_W-1:0] cmd_idx;
  logic [SIZE_BITS-1:0]         cmd_amt;
  logic [CW-1:0]                lim;

  // Scan state
  logic [CW-1:0]        scan_idx;
  logic                 rd_vld;
  logic [AW-1:0]        rd_idx;
  logic                 rd_ok;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 found;
  logic                 hit;
  logic [AW-1:0]        best_idx;
  logic [SIZE_BITS-1:0] best_size;
  logic [bfha_pkg::TOTAL_W-1:0] count;

  // Incoming fields
  logic [bfha_pkg::INDEX_W-1:0] in_idx;
  logic [SIZE_BITS-1:0]         in_amt;
  logic [CW-1:0]                lim_next;

  assign in_idx = s_tdata[bfha_pkg::INDEX_W-1:0];
  assign in_amt = SIZE_BITS'(s_tdata[bfha_pkg::INDEX_W +: bfha_pkg::AMOUNT_W]);

  // Clamp the scan length to the table depth
  always_comb begin
    if (32'(holes_in_use) > 32'(MAX_HOLES)) begin
      lim_next = CW'(MAX_HOLES);
    end else begin
      lim_next = CW'(holes_in_use);
    end
  end

  // Scan evaluation of the entry read last cycle
  logic [SIZE_BITS-1:0] sz;
  logic                 issue;
  logic                 eval;
  logic                 nonempty;
  logic                 fits;
  logic                 better;
  logic                 exact;

  always_comb begin
    sz       = rd_ok ? rd_data : '0;
    issue    = ctl.scan_en && !hit && (scan_idx < lim);
    eval     = ctl.scan_en && rd_vld && !hit;
    nonempty = (sz != '0);
    fits     = nonempty && (sz >= cmd_amt);
    better   = fits && (!found || (sz < best_size));
    exact    = fits && (sz == cmd_amt);
  end

  assign sts.scan_done = hit || (!(scan_idx < lim) && !rd_vld);
  assign sts.out_busy  = m_tvalid && !m_tready;

  // Finishing write-back
  logic                 write_ok;
  logic                 mem_we;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] shrunk;

  always_comb begin
    write_ok = (32'(cmd_idx) < 32'(MAX_HOLES));
    shrunk   = best_size - cmd_amt;
    if (cmd_code == bfha_pkg::CMD_ALLOC) begin
      mem_we  = ctl.finish && found;
      wr_addr = best_idx;
      wr_data = shrunk;
    end else begin
      mem_we  = ctl.finish && write_ok;
      wr_addr = AW'(cmd_idx);
      wr_data = cmd_amt;
    end
  end

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[scan_idx[AW-1:0]];
  end

  // Valid bits, configuration and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      holes_in_use <= bfha_pkg::HIU_RESET;
      scan_idx     <= '0;
      rd_vld       <= 1'b0;
      found        <= 1'b0;
      hit          <= 1'b0;
      count        <= '0;
    end else begin
      if (mem_we) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cfg_we) begin
        holes_in_use <= cfg_wdata;
      end
      if (ctl.load) begin
        scan_idx <= '0;
        rd_vld   <= 1'b0;
        found    <= 1'b0;
        hit      <= 1'b0;
      end else begin
        rd_vld <= issue;
        if (issue) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (eval && better) begin
          found <= 1'b1;
        end
        if (eval && exact) begin
          hit <= 1'b1;
        end
        if (eval && nonempty && (count != '1)) begin
          count <= count + 32'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_code <= s_tuser;
      cmd_idx  <= in_idx;
      cmd_amt  <= in_amt;
      lim      <= lim_next;
    end
    if (issue) begin
      rd_idx <= scan_idx[AW-1:0];
      rd_ok  <= valid[scan_idx[AW-1:0]];
    end
    if (eval && better) begin
      best_idx  <= rd_idx;
      best_size <= sz;
    end
  end

  // Result fields
  logic                          res_placed;
  logic [bfha_pkg::INDEX_W-1:0]  res_chosen;
  logic [bfha_pkg::LEFT_W-1:0]   res_left;

  always_comb begin
    if (cmd_code == bfha_pkg::CMD_ALLOC) begin
      res_placed = found;
      res_chosen = found ? bfha_pkg::INDEX_W'(best_idx) : '0;
      res_left   = found ? bfha_pkg::LEFT_W'(shrunk) : '0;
    end else begin
      res_placed = 1'b0;
      res_chosen = cmd_idx;
      res_left   = write_ok ? bfha_pkg::LEFT_W'(cmd_amt) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      m_tdata <= {{bfha_pkg::OUT_PAD_W{1'b0}}, count, res_left, res_chosen, res_placed};
    end
  end

  // A recorded best hole always covers the request
  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    found |-> (best_size >= cmd_amt))
    else $error("best hole smaller than request");

  // An exact fit can only follow a recorded best hole
  a_hit_found: assert property (@(posedge clk) disable iff (rst)
    hit |-> found)
    else $error("exact fit without a best hole");

  // No further entry is evaluated after an exact fit
  a_hit_stops: assert property (@(posedge clk) disable iff (rst)
    hit |=> !rd_vld)
    else $error("scan continued past exact fit");

  // Finishing always presents a result
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> m_tvalid)
    else $error("finish did not load output register");

endmodule

/* src/best_fit_hole_allocator_unit.sv */
// Top level of the best-fit hole allocator: controller plus datapath.
//
//  Channel  Dir  Signals                        Contents
//  s_*      in   tvalid tready tuser tdata      command; hole_index, amount
//  m_*      out  tvalid tready tdata            placed, chosen_hole, space_left, total
//  cfg_*    in   we wdata                       holes_in_use
//
// A write transaction goes from acceptance through the finish state to the result; a
// request first scans L = min(holes_in_use, MAX_HOLES) entries, one entry per cycle
// over the single read port of the hole table (fewer when an exact fit ends it).
// Reset is synchronous and empties every hole, clears the count, sets holes_in_use to 8.
// One transaction is in flight at a time; a result waiting in the output register
// does not block acceptance, only the final write-back of the next transaction.
module best_fit_hole_allocator_unit #(
  parameter int MAX_HOLES = bfha_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = bfha_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bfha_pkg::CMD_W-1:0]        s_tuser,   // command
  input  logic [bfha_pkg::IN_DATA_W-1:0]    s_tdata,   // hole_index, amount
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bfha_pkg::OUT_DATA_W-1:0]   m_tdata,   // placed, chosen_hole,
                                                       // space_left, comparison_total
  input  logic                              cfg_we,
  input  logic [bfha_pkg::HIU_W-1:0]        cfg_wdata
);

  bfha_pkg::bfha_ctl_t ctl;
  bfha_pkg::bfha_sts_t sts;

  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .ctl      (ctl)
  );

  bfha_datapath #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* bench/best_fit_hole_allocator_unit_tb.sv */
// Self-checking bench for the best-fit hole allocator: directed table, then random phases.
module best_fit_hole_allocator_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W      = bfha_pkg::CMD_W;
  localparam int INDEX_W    = bfha_pkg::INDEX_W;
  localparam int AMOUNT_W   = bfha_pkg::AMOUNT_W;
  localparam int LEFT_W     = bfha_pkg::LEFT_W;
  localparam int TOTAL_W    = bfha_pkg::TOTAL_W;
  localparam int HIU_W      = bfha_pkg::HIU_W;
  localparam int IN_DATA_W  = bfha_pkg::IN_DATA_W;
  localparam int IN_PAD_W   = bfha_pkg::IN_PAD_W;
  localparam int OUT_DATA_W = bfha_pkg::OUT_DATA_W;

  localparam int NUM_HOLES   = bfha_pkg::MAX_HOLES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RX_HOLD_LEN = 400;

  // One allocation outcome, as carried on the result stream
  typedef struct packed {
    logic               placed;
    logic [INDEX_W-1:0] chosen;
    logic [LEFT_W-1:0]  left;
    logic [TOTAL_W-1:0] total;
  } alloc_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  idx;
    logic [AMOUNT_W-1:0] amt;   // holes_in_use value on a ROW_CFG row
    alloc_result_t       known;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CMD_W-1:0]      s_tuser = bfha_pkg::CMD_WRITE;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [HIU_W-1:0]      cfg_wdata = '0;

  // Predictor state
  logic [AMOUNT_W-1:0] hole_table_copy [NUM_HOLES];
  logic [TOTAL_W-1:0]  compare_total_copy;
  logic [HIU_W-1:0]    holes_in_use_copy;

  alloc_result_t pending_results [$];
  dir_row_t      dir_table [$];
  int            fail_count = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;
  int            rx_hold_left = 0;
  bit            rx_hold_done = 1'b0;
  int            rx_seen = 0;

  best_fit_hole_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Write or best-fit scan of first holes_in_use entries; updates the copy of the table
  function automatic alloc_result_t predict_best_fit(input logic [CMD_W-1:0] cmd,
                                                     input logic [INDEX_W-1:0] idx,
                                                     input logic [AMOUNT_W-1:0] amt);
    alloc_result_t r;
    int            scan_len;
    int            best;
    logic          found;
    r = '0;
    if (cmd == bfha_pkg::CMD_WRITE) begin
      hole_table_copy[idx] = amt;
      r.chosen = idx;
      r.left   = amt;
    end else begin
      scan_len = (holes_in_use_copy > NUM_HOLES) ? NUM_HOLES : int'(holes_in_use_copy);
      found = 1'b0;
      best  = 0;
      for (int j = 0; j < scan_len; j++) begin
        if (hole_table_copy[j] != '0) begin
          if (compare_total_copy != '1) compare_total_copy = compare_total_copy + 1'b1;
          if (hole_table_copy[j] >= amt) begin
            if (!found || hole_table_copy[j] < hole_table_copy[best]) begin
              best  = j;
              found = 1'b1;
            end
            // exact fit ends the scan
            if (hole_table_copy[best] == amt) break;
          end
        end
      end
      if (found) begin
        hole_table_copy[best] = hole_table_copy[best] - amt;
        r.placed = 1'b1;
        r.chosen = INDEX_W'(best);
        r.left   = hole_table_copy[best];
      end
    end
    r.total = compare_total_copy;
    return r;
  endfunction

  // Offer one transaction, wait for acceptance, queue its expected result
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt, input bit use_known,
                           input alloc_result_t known);
    alloc_result_t pred;
    if (!no_idle) begin
      while ($urandom_range(99) < 23) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{IN_PAD_W{1'b0}}, amt, idx};
    do @(posedge clk); while (!s_tready);
    pred = predict_best_fit(cmd, idx, amt);
    pending_results.push_back(use_known ? known : pred);
  endtask

  // Register write once every result is out
  task automatic set_holes_in_use(input logic [HIU_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    holes_in_use_copy = value;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [CMD_W-1:0] cmd,
                         input logic [INDEX_W-1:0] idx, input logic [AMOUNT_W-1:0] amt,
                         input alloc_result_t known);
    dir_row_t row;
    row.kind  = kind;
    row.cmd   = cmd;
    row.idx   = idx;
    row.amt   = amt;
    row.known = known;
    dir_table.push_back(row);
  endtask

  // Stimulus
  initial begin
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  idx;
    logic [AMOUNT_W-1:0] amt;
    logic [HIU_W-1:0]    hiu;
    int                  scan_len;
    int                  pick;

    foreach (hole_table_copy[i]) hole_table_copy[i] = '0;
    compare_total_copy = '0;
    holes_in_use_copy  = bfha_pkg::HIU_RESET;

    // empty table after reset, extremes, ties, exact fit, zero request, odd hole counts
    add_row(ROW_KNOWN, bfha_pkg::CMD_ALLOC, 4'd0,  16'd5,    '{1'b0, 4'd0,  16'd0,    32'd0});
    add_row(ROW_KNOWN, bfha_pkg::CMD_WRITE, 4'd0,  16'hFFFF, '{1'b0, 4'd0,  16'hFFFF, 32'd0});
    add_row(ROW_KNOWN, bfha_pkg::CMD_WRITE, 4'd15, 16'd0,    '{1'b0, 4'd15, 16'd0,    32'd0});
    add_row(ROW_KNOWN, bfha_pkg::CMD_WRITE, 4'd15, 16'hFFFF, '{1'b0, 4'd15, 16'hFFFF, 32'd0});
    add_row(ROW_KNOWN, bfha_pkg::CMD_WRITE, 4'd3,  16'd100,  '{1'b0, 4'd3,  16'd100,  32'd0});
    add_row(ROW_ITEM,  bfha_pkg::CMD_WRITE, 4'd5,  16'd40,   '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_WRITE, 4'd6,  16'd40,   '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_WRITE, 4'd7,  16'd1,    '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd0,  16'd40,   '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd15, 16'd40,   '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd9,  16'd0,    '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd0,  16'hFFFF, '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd0,  16'hFFFF, '0);
    add_row(ROW_CFG,   bfha_pkg::CMD_WRITE, 4'd0,  16'd16,   '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd0,  16'hFFFF, '0);
    add_row(ROW_CFG,   bfha_pkg::CMD_WRITE, 4'd0,  16'd0,    '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd0,  16'd1,    '0);
    add_row(ROW_CFG,   bfha_pkg::CMD_WRITE, 4'd0,  16'd31,   '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_WRITE, 4'd10, 16'd7,    '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_WRITE, 4'd1,  16'h5555, '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_WRITE, 4'd2,  16'hAAAA, '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd6,  16'd7,    '0);
    add_row(ROW_CFG,   bfha_pkg::CMD_WRITE, 4'd0,  16'd1,    '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_WRITE, 4'd0,  16'd3,    '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd0,  16'd0,    '0);
    add_row(ROW_ITEM,  bfha_pkg::CMD_ALLOC, 4'd0,  16'd4,    '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        set_holes_in_use(dir_table[i].amt[HIU_W-1:0]);
      end else begin
        send_item(dir_table[i].cmd, dir_table[i].idx, dir_table[i].amt,
                  dir_table[i].kind == ROW_KNOWN, dir_table[i].known);
      end
    end

    // Random phases, one hole count each; phase five runs with no idling
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: hiu = 5'd16;
        1: hiu = 5'd1;
        2: hiu = 5'd0;
        3: hiu = 5'd31;
        4: hiu = 5'd5;
        5: hiu = 5'd16;
        6: hiu = 5'($urandom_range(31));
        7: hiu = 5'd12;
        default: hiu = 5'd17;
      endcase
      set_holes_in_use(hiu);
      no_idle = (p == 5);
      scan_len = (hiu > NUM_HOLES) ? NUM_HOLES : int'(hiu);
      for (int n = 0; n < 100; n++) begin
        cmd = ($urandom_range(99) < 40) ? bfha_pkg::CMD_WRITE : bfha_pkg::CMD_ALLOC;
        if (scan_len > 0 && $urandom_range(1) == 1) begin
          idx = INDEX_W'($urandom_range(scan_len - 1));
        end else begin
          idx = INDEX_W'($urandom_range(15));
        end
        pick = $urandom_range(99);
        if (cmd == bfha_pkg::CMD_WRITE) begin
          if (pick < 15) amt = '0;
          else if (pick < 65) amt = AMOUNT_W'($urandom_range(64, 1));
          else amt = AMOUNT_W'($urandom);
        end else begin
          // exact fits against live holes, small sizes, zero, full range
          if (pick < 40) amt = hole_table_copy[$urandom_range(NUM_HOLES - 1)];
          else if (pick < 70) amt = AMOUNT_W'($urandom_range(64));
          else if (pick < 80) amt = '0;
          else amt = AMOUNT_W'($urandom);
        end
        send_item(cmd, idx, amt, 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    // Drain and finish
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold while the sender keeps offering
  always @(posedge clk) begin
    if (m_tvalid && m_tready) rx_seen++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_hold_done && rx_seen >= 250) begin
      rx_hold_done = 1'b1;
      rx_hold_left = RX_HOLD_LEN;
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 23);
    end
  end

  // Result checker: every transaction against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.placed = m_tdata[0];
      got.chosen = m_tdata[INDEX_W:1];
      got.left   = m_tdata[INDEX_W+LEFT_W:INDEX_W+1];
      got.total  = m_tdata[INDEX_W+LEFT_W+TOTAL_W:INDEX_W+LEFT_W+1];
      if (pending_results.size() == 0) begin
        if (fail_count < 10) $display("unexpected result %p", got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.placed !== want.placed || got.chosen !== want.chosen ||
            got.left !== want.left || got.total !== want.total) begin
          if (fail_count < 10) begin
            $display("mismatch: placed %0d/%0d hole %0d/%0d left %0d/%0d total %0d/%0d",
                     want.placed, got.placed, want.chosen, got.chosen,
                     want.left, got.left, want.total, got.total);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
